/* hdl/rip_pkg.sv */
// Shared types, widths and constants of the range-image projection pipeline.
package rip_pkg;

  localparam int CoordW    = 18;
  localparam int IntenW    = 16;
  localparam int RowW      = 7;
  localparam int ColW      = 12;
  localparam int RangeW    = 16;
  localparam int IcodeW    = 8;
  localparam int RowCntW   = 8;
  localparam int ColCntW   = 13;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 13;

  localparam int SqW       = 2 * CoordW;
  localparam int RootW     = CoordW;
  localparam int AngW      = 24;
  localparam int CorW      = 38;
  localparam int CorShift  = 16;
  localparam int CorSteps  = 21;

  localparam int DefMaxRows = 128;
  localparam int DefMaxCols = 4096;

  localparam logic [RowCntW-1:0] RowCountReset = RowCntW'(64);
  localparam logic [ColCntW-1:0] ColCountReset = ColCntW'(2048);

  localparam logic signed [AngW-1:0] AngPi      = 24'sd3294199;
  localparam logic [AngW-1:0]        AngTwoPi   = 24'd6588397;
  localparam logic signed [AngW-1:0] AngFovDown = 24'sd453867;
  localparam logic [AngW-1:0]        AngFov     = 24'd490470;

  // Division by 5 through a reciprocal: exact for every 18-bit range.
  localparam int RangeRecipW = 20;
  localparam logic [RangeRecipW-1:0] RangeRecip = 20'd838861;
  localparam int RangeShift = 22;

  // Register stages of the division by the angular span.
  localparam int CdivLat = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_COUNT = 4'd0,
    CFG_COL_COUNT = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [IntenW-1:0]        intensity;
  } point_t;

  typedef struct packed {
    logic signed [AngW-1:0] elev;
    logic signed [AngW-1:0] az;
    logic [RootW-1:0]       rxy;
    logic [IntenW-1:0]      intensity;
  } ang_res_t;

  function automatic logic signed [AngW-1:0] cordic_step_angle(input int idx);
    logic signed [AngW-1:0] a;
    case (idx)
      0:       a = 24'sd823550;
      1:       a = 24'sd486170;
      2:       a = 24'sd256879;
      3:       a = 24'sd130396;
      4:       a = 24'sd65451;
      5:       a = 24'sd32757;
      6:       a = 24'sd16383;
      default: a = AngW'(24'sd1 <<< (20 - idx));
    endcase
    return a;
  endfunction

endpackage

/* hdl/rip_sqrt.sv */
// Pipelined horizontal range: squares, sum, then one root bit per stage.
module rip_sqrt import rip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  point_t           pt_i,
  output logic             valid_o,
  output point_t           pt_o,
  output logic [RootW-1:0] root_o
);

  localparam int RemW = SqW + 1;

  logic                     sq_valid_q;
  logic [SqW-1:0]           sqx_q, sqy_q;
  point_t                   sq_pt_q;
  logic signed [SqW-1:0]    sqx_d, sqy_d;

  logic                     v_q    [0:RootW];
  logic [RemW-1:0]          rem_q  [0:RootW];
  logic [RootW-1:0]         root_q [0:RootW];
  point_t                   pt_q   [0:RootW];

  assign sqx_d = pt_i.x * pt_i.x;
  assign sqy_d = pt_i.y * pt_i.y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      v_q[0]     <= 1'b0;
    end else if (en_i) begin
      sq_valid_q <= valid_i;
      v_q[0]     <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      sq_pt_q   <= pt_i;
      rem_q[0]  <= RemW'(sqx_q) + RemW'(sqy_q);
      root_q[0] <= '0;
      pt_q[0]   <= sq_pt_q;
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam int Bit = RootW - 1 - k;
    logic [RemW-1:0] trial;
    logic            take;

    assign trial = (RemW'(root_q[k]) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    assign take  = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (RootW'(1) << Bit)) : root_q[k];
        pt_q[k+1]   <= pt_q[k];
      end
    end
  end

  assign valid_o = v_q[RootW];
  assign pt_o    = pt_q[RootW];
  assign root_o  = root_q[RootW];

endmodule

/* hdl/rip_angles.sv */
// Two-lane pipelined CORDIC in vectoring mode for elevation and azimuth.
module rip_angles import rip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  point_t           pt_i,
  input  logic [RootW-1:0] root_i,
  output logic             valid_o,
  output ang_res_t         res_o
);

  localparam int InW = CoordW + 1;

  logic                   v_q    [0:CorSteps];
  logic [RootW-1:0]       rxy_q  [0:CorSteps];
  logic [IntenW-1:0]      inten_q[0:CorSteps];

  logic                   valid_q;
  ang_res_t               res_q;
  logic signed [AngW-1:0] lane_ang[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0]  <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v_q[0]  <= valid_i;
      valid_q <= v_q[CorSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rxy_q[0]      <= root_i;
      inten_q[0]    <= pt_i.intensity;
      res_q.elev      <= lane_ang[0];
      res_q.az        <= lane_ang[1];
      res_q.rxy       <= rxy_q[CorSteps];
      res_q.intensity <= inten_q[CorSteps];
    end
  end

  for (genvar k = 0; k < CorSteps; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rxy_q[k+1]   <= rxy_q[k];
        inten_q[k+1] <= inten_q[k];
      end
    end
  end

  // Lane 0 is atan2(z, rxy), lane 1 is atan2(y, x).
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [InW-1:0]  xx, yy, xa, ya;
    logic                   x_neg;
    logic signed [AngW-1:0] base;

    logic signed [CorW-1:0] px_q  [0:CorSteps];
    logic signed [CorW-1:0] py_q  [0:CorSteps];
    logic signed [AngW-1:0] ang_q [0:CorSteps];
    logic                   zero_q[0:CorSteps];
    logic                   xneg_q[0:CorSteps];

    if (l == 0) begin : g_elev
      assign xx = $signed({1'b0, root_i});
      assign yy = InW'(pt_i.z);
    end else begin : g_az
      assign xx = InW'(pt_i.x);
      assign yy = InW'(pt_i.y);
    end

    assign x_neg = xx[InW-1];
    assign xa    = x_neg ? -xx : xx;
    assign ya    = x_neg ? -yy : yy;
    assign base  = !x_neg ? '0 : (yy > 0 ? AngPi : -AngPi);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        px_q[0]   <= CorW'(xa) <<< CorShift;
        py_q[0]   <= CorW'(ya) <<< CorShift;
        ang_q[0]  <= base;
        zero_q[0] <= yy == '0;
        xneg_q[0] <= x_neg;
      end
    end

    for (genvar k = 0; k < CorSteps; k++) begin : g_step
      logic signed [CorW-1:0] sx, sy;
      logic                   up;
      assign sx = px_q[k] >>> k;
      assign sy = py_q[k] >>> k;
      assign up = py_q[k] > 0;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          px_q[k+1]   <= up ? px_q[k] + sy : px_q[k] - sy;
          py_q[k+1]   <= up ? py_q[k] - sx : py_q[k] + sx;
          ang_q[k+1]  <= up ? ang_q[k] + cordic_step_angle(k)
                            : ang_q[k] - cordic_step_angle(k);
          zero_q[k+1] <= zero_q[k];
          xneg_q[k+1] <= xneg_q[k];
        end
      end
    end

    // A zero second coordinate bypasses the iteration entirely.
    assign lane_ang[l] = !zero_q[CorSteps] ? ang_q[CorSteps]
                       : (xneg_q[CorSteps] ? AngPi : '0);
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* hdl/rip_bin.sv */
// Pixel binning: angle offset, scale by image size, reciprocal division by span, clamp.
module rip_bin import rip_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols,
  localparam int RcW = $clog2(MAX_ROWS + 1),
  localparam int CcW = $clog2(MAX_COLS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ang_res_t          res_i,
  input  logic [RcW-1:0]    rows_i,
  input  logic [CcW-1:0]    cols_i,
  output logic              valid_o,
  output logic [RowW-1:0]   pixel_row_o,
  output logic [ColW-1:0]   pixel_col_o,
  output logic [RangeW-1:0] range_code_o,
  output logic [IcodeW-1:0] intensity_code_o
);

  localparam int MagW  = AngW;
  localparam int CntW  = (RcW > CcW) ? RcW : CcW;
  localparam int PW    = MagW + CntW;
  localparam int RPW   = RootW + RangeRecipW;
  localparam int RqW   = PW - $clog2(int'(AngFov) + 1) + 1;
  localparam int CqW   = PW - $clog2(int'(AngTwoPi) + 1) + 1;
  localparam int QmW   = (RqW > CqW) ? RqW : CqW;
  localparam int SW    = (QmW > CntW) ? QmW : CntW;

  // Stage 0: offsets, range reciprocal product, intensity code.
  logic signed [AngW:0]   num_r, num_c;
  logic [IcodeW-1:0]      ic_est;
  logic [IntenW:0]        ic_back;

  logic                   s0_v_q;
  logic                   s0_rpos_q, s0_cpos_q;
  logic [MagW-1:0]        s0_rmag_q, s0_cmag_q;
  logic [RPW-1:0]         s0_rng_q;
  logic [IcodeW-1:0]      s0_ic_q;

  assign num_r   = $signed({res_i.elev[AngW-1], res_i.elev}) + (AngW+1)'(AngFovDown);
  assign num_c   = $signed({res_i.az[AngW-1], res_i.az}) + (AngW+1)'(AngPi);
  assign ic_est  = res_i.intensity[IntenW-1:IntenW-IcodeW];
  assign ic_back = {1'b0, ic_est, 8'd0} + (IntenW+1)'(ic_est);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_rpos_q <= !num_r[AngW] && (num_r != '0);
      s0_cpos_q <= !num_c[AngW] && (num_c != '0);
      s0_rmag_q <= num_r[MagW-1:0];
      s0_cmag_q <= num_c[MagW-1:0];
      s0_rng_q  <= RPW'(res_i.rxy) * RPW'(RangeRecip);
      s0_ic_q   <= (ic_back > (IntenW+1)'(res_i.intensity)) ? ic_est - 1'b1 : ic_est;
    end
  end

  // Stage 1: scale by image size.
  logic [PW-1:0]     prod_r, prod_c;
  logic [PW-1:0]     p_r_q, p_c_q;
  logic              d_v_q   [0:CdivLat];
  logic [RangeW-1:0] rng_q   [0:CdivLat];
  logic [IcodeW-1:0] ic_q    [0:CdivLat];

  assign prod_r = s0_rpos_q ? PW'(s0_rmag_q) * PW'(rows_i) : '0;
  assign prod_c = s0_cpos_q ? PW'(s0_cmag_q) * PW'(cols_i) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q[0] <= 1'b0;
    end else if (en_i) begin
      d_v_q[0] <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_r_q    <= prod_r;
      p_c_q    <= prod_c;
      rng_q[0] <= s0_rng_q[RPW-1:RangeShift];
      ic_q[0]  <= s0_ic_q;
    end
  end

  for (genvar k = 0; k < CdivLat; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        d_v_q[k+1] <= d_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rng_q[k+1] <= rng_q[k];
        ic_q[k+1]  <= ic_q[k];
      end
    end
  end

  // Floor division by the span: the reciprocal estimate is at most one low,
  // so a single compare against the remainder finishes it.
  logic [PW-1:0]  div_num[2];
  logic [QmW-1:0] div_quo[2];

  assign div_num[0] = p_r_q;
  assign div_num[1] = p_c_q;

  for (genvar l = 0; l < 2; l++) begin : g_div
    localparam int Dv  = (l == 0) ? int'(AngFov) : int'(AngTwoPi);
    localparam int DvW = $clog2(Dv + 1);
    localparam int QW  = PW - DvW + 1;
    localparam int LoW = PW / 2;
    localparam int HiW = PW - LoW;
    localparam longint unsigned Recip = (64'd1 << PW) / 64'(Dv);
    localparam logic [QW-1:0]  RecipV = QW'(Recip);
    localparam logic [DvW-1:0] DvV    = DvW'(Dv);

    logic [HiW+QW-1:0]  hi_prod_q;
    logic [LoW+QW-1:0]  lo_prod_q;
    logic [PW-1:0]      a_num_q, b_num_q, c_num_q;
    logic [PW+QW-1:0]   sum;
    logic [QW-1:0]      b_est_q, c_est_q, quo_q;
    logic [QW+DvW-1:0]  c_prod_q;
    logic [PW:0]        rem;
    logic               fix;

    assign sum = {hi_prod_q, {LoW{1'b0}}} + (PW+QW)'(lo_prod_q);
    assign rem = (PW+1)'(c_num_q) - c_prod_q;
    assign fix = rem >= (PW+1)'(DvV);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hi_prod_q <= (HiW+QW)'(div_num[l][PW-1:LoW]) * (HiW+QW)'(RecipV);
        lo_prod_q <= (LoW+QW)'(div_num[l][LoW-1:0]) * (LoW+QW)'(RecipV);
        a_num_q   <= div_num[l];
        b_est_q   <= sum[PW+QW-1:PW];
        b_num_q   <= a_num_q;
        c_prod_q  <= (QW+DvW)'(b_est_q) * (QW+DvW)'(DvV);
        c_est_q   <= b_est_q;
        c_num_q   <= b_num_q;
        quo_q     <= fix ? c_est_q + 1'b1 : c_est_q;
      end
    end

    assign div_quo[l] = QmW'(quo_q);
  end

  // Final stage: saturate at the last row and column.
  logic [SW-1:0] rq_f, cq_f, rlast, clast, rsel, csel;

  assign rq_f  = SW'(div_quo[0]);
  assign cq_f  = SW'(div_quo[1]);
  assign rlast = SW'(rows_i) - 1'b1;
  assign clast = SW'(cols_i) - 1'b1;
  assign rsel  = (rq_f > rlast) ? rlast : rq_f;
  assign csel  = (cq_f > clast) ? clast : cq_f;

  logic              out_v_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [RangeW-1:0] range_q;
  logic [IcodeW-1:0] icode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= d_v_q[CdivLat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q   <= rsel[RowW-1:0];
      col_q   <= csel[ColW-1:0];
      range_q <= rng_q[CdivLat];
      icode_q <= ic_q[CdivLat];
    end
  end

  assign valid_o          = out_v_q;
  assign pixel_row_o      = row_q;
  assign pixel_col_o      = col_q;
  assign range_code_o     = range_q;
  assign intensity_code_o = icode_q;

endmodule

/* hdl/lidar_point_range_image_projection_top.sv */
// Top level of the lidar point to range-image pixel projection pipeline.
//
// A point (x, y, z in millimetres, intensity fraction) enters on the input
// channel; a transaction completes when valid_i is high and stall_o is low.
// One result transaction per point leaves on the output channel, taken when
// valid_o is high and stall_i is low. Points are accepted back to back, one
// per cycle while the output is not stalled. A point passes through the square
// root (squares and their sum registered, then one root bit a stage), the CORDIC
// (21 iterations plus entry and exit registers) and the binning (offset,
// image-size product, reciprocal division by the angular span, clamp).
// While a result waits with stall_i high the whole pipeline holds and
// stall_o is raised; nothing is dropped or repeated.
// Reset empties the pipeline and sets row_count to 64 and column_count to
// 2048. The configuration channel (index 0 rows, 1 columns) is always ready
// and should be written only while the pipeline is empty.
module lidar_point_range_image_projection_top import rip_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic [IntenW-1:0]        point_intensity_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [RowW-1:0]          pixel_row_o,
  output logic [ColW-1:0]          pixel_col_o,
  output logic [RangeW-1:0]        range_code_o,
  output logic [IcodeW-1:0]        intensity_code_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i
);

  localparam int RcW = $clog2(MAX_ROWS + 1);
  localparam int CcW = $clog2(MAX_COLS + 1);

  logic [RowCntW-1:0] row_count_q, row_count_d;
  logic [ColCntW-1:0] col_count_q, col_count_d;
  logic [RcW-1:0]     rows_eff;
  logic [CcW-1:0]     cols_eff;
  logic               en;

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_COUNT: row_count_d = cfg_data_i[RowCntW-1:0];
        CFG_COL_COUNT: col_count_d = cfg_data_i[ColCntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountReset;
      col_count_q <= ColCountReset;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
    end
  end

  // A count of zero behaves as one; larger than the maximum saturates.
  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = RcW'(1);
    end else if (int'(row_count_q) > MAX_ROWS) begin
      rows_eff = RcW'(MAX_ROWS);
    end else begin
      rows_eff = RcW'(row_count_q);
    end
    if (col_count_q == '0) begin
      cols_eff = CcW'(1);
    end else if (int'(col_count_q) > MAX_COLS) begin
      cols_eff = CcW'(MAX_COLS);
    end else begin
      cols_eff = CcW'(col_count_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign en          = !(valid_o && stall_i);
  assign stall_o     = !en;

  point_t           pt_in, sq_pt;
  logic             sq_valid, ang_valid;
  logic [RootW-1:0] sq_root;
  ang_res_t         ang_res;

  assign pt_in.x         = point_x_i;
  assign pt_in.y         = point_y_i;
  assign pt_in.z         = point_z_i;
  assign pt_in.intensity = point_intensity_i;

  rip_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .pt_i    (pt_in),
    .valid_o (sq_valid),
    .pt_o    (sq_pt),
    .root_o  (sq_root)
  );

  rip_angles u_angles (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .pt_i    (sq_pt),
    .root_i  (sq_root),
    .valid_o (ang_valid),
    .res_o   (ang_res)
  );

  rip_bin #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_bin (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (ang_valid),
    .res_i            (ang_res),
    .rows_i           (rows_eff),
    .cols_i           (cols_eff),
    .valid_o          (valid_o),
    .pixel_row_o      (pixel_row_o),
    .pixel_col_o      (pixel_col_o),
    .range_code_o     (range_code_o),
    .intensity_code_o (intensity_code_o)
  );

endmodule

/* sim/lidar_point_range_image_projection_checker.sv */
// Checker for the range-image projection block: predicts each pixel and compares results.
module lidar_point_range_image_projection_checker import rip_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic                     stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic [IntenW-1:0]        point_intensity_i,
  input  logic                     valid_o,
  input  logic                     stall_i,
  input  logic [RowW-1:0]          pixel_row_o,
  input  logic [ColW-1:0]          pixel_col_o,
  input  logic [RangeW-1:0]        range_code_o,
  input  logic [IcodeW-1:0]        intensity_code_o,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [RangeW-1:0] range_code;
    logic [IcodeW-1:0] icode;
  } pixel_t;

  localparam longint AngleFovDown = 453867;
  localparam longint AngleFov     = 490470;
  localparam longint AnglePi      = 3294199;
  localparam longint AngleTwoPi   = 6588397;

  logic [RowCntW-1:0] row_count_q;
  logic [ColCntW-1:0] col_count_q;
  pixel_t             pixel_q[$];

  function automatic longint step_angle(input int i);
    longint a;
    case (i)
      0:       a = 823550;
      1:       a = 486170;
      2:       a = 256879;
      3:       a = 130396;
      4:       a = 65451;
      5:       a = 32757;
      6:       a = 16383;
      default: a = longint'(1) << (20 - i);
    endcase
    return a;
  endfunction

  // Vectoring CORDIC; the left half-plane is first folded by a half turn.
  function automatic longint vector_angle(input longint yy, input longint xx);
    longint ang, px, py, nx, ny;
    ang = 0;
    if (yy == 0) return (xx < 0) ? AnglePi : 0;
    if (xx < 0) begin
      ang = (yy > 0) ? AnglePi : -AnglePi;
      xx = -xx;
      yy = -yy;
    end
    px = xx * 65536;
    py = yy * 65536;
    for (int i = 0; i < CorSteps; i++) begin
      if (py > 0) begin
        nx = px + (py >>> i);
        ny = py - (px >>> i);
        ang += step_angle(i);
      end else begin
        nx = px - (py >>> i);
        ny = py + (px >>> i);
        ang -= step_angle(i);
      end
      px = nx;
      py = ny;
    end
    return ang;
  endfunction

  function automatic longint floor_root(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint bin_of(input longint num, input longint count, input longint span);
    longint idx;
    if (num <= 0) return 0;
    idx = (num * count) / span;
    if (idx > count - 1) idx = count - 1;
    return idx;
  endfunction

  function automatic pixel_t project(input longint x, input longint y, input longint z,
                                     input longint inten);
    pixel_t p;
    longint rows, cols, rxy, code;
    rows = row_count_q;
    cols = col_count_q;
    if (rows < 1) rows = 1;
    if (rows > DefMaxRows) rows = DefMaxRows;
    if (cols < 1) cols = 1;
    if (cols > DefMaxCols) cols = DefMaxCols;
    rxy = floor_root(longint'(x * x + y * y));
    code = rxy / 5;
    if (code > 65535) code = 65535;
    p.row = RowW'(bin_of(vector_angle(z, rxy) + AngleFovDown, rows, AngleFov));
    p.col = ColW'(bin_of(vector_angle(y, x) + AnglePi, cols, AngleTwoPi));
    p.range_code = RangeW'(code);
    p.icode = IcodeW'(inten / 257);
    return p;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count_o++;
  endtask

  // Sampled mid-cycle: inputs and outputs are stable until the next rising edge.
  always @(negedge clk_i) begin
    pixel_t want;
    if (!rst_ni) begin
      row_count_q = RowCountReset;
      col_count_q = ColCountReset;
      pixel_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ROW_COUNT: row_count_q = cfg_data_i[RowCntW-1:0];
          CFG_COL_COUNT: col_count_q = cfg_data_i;
          default: ;
        endcase
      end
      if (valid_i && !stall_o) begin
        pixel_q.push_back(project(point_x_i, point_y_i, point_z_i, point_intensity_i));
      end
      if (valid_o && !stall_i) begin
        if (pixel_q.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_row_o !== want.row) report("pixel_row", pixel_row_o, want.row);
          if (pixel_col_o !== want.col) report("pixel_col", pixel_col_o, want.col);
          if (range_code_o !== want.range_code)
            report("range_code", range_code_o, want.range_code);
          if (intensity_code_o !== want.icode)
            report("intensity_code", intensity_code_o, want.icode);
        end
      end
    end
    pending_o = pixel_q.size();
  end

endmodule

/* sim/lidar_point_range_image_projection_top_tb.sv */
// Testbench top: drives points and register writes into the projection block.
module lidar_point_range_image_projection_top_tb import rip_pkg::*;;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd9;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 80;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     valid_i;
  logic                     stall_o;
  logic signed [CoordW-1:0] point_x_i;
  logic signed [CoordW-1:0] point_y_i;
  logic signed [CoordW-1:0] point_z_i;
  logic [IntenW-1:0]        point_intensity_i;
  logic                     valid_o;
  logic                     stall_i;
  logic [RowW-1:0]          pixel_row_o;
  logic [ColW-1:0]          pixel_col_o;
  logic [RangeW-1:0]        range_code_o;
  logic [IcodeW-1:0]        intensity_code_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  int                       fail_count;
  int                       pending;
  int                       cycle_count = 0;
  bit                       no_gaps;

  lidar_point_range_image_projection_top dut (.*);

  lidar_point_range_image_projection_checker checker_i (
    .clk_i, .rst_ni, .valid_i, .stall_o, .point_x_i, .point_y_i, .point_z_i,
    .point_intensity_i, .valid_o, .stall_i, .pixel_row_o, .pixel_col_o,
    .range_code_o, .intensity_code_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: a random stall, possibly none, before each result transaction.
  initial begin
    int n;
    bit taken;
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      n = no_gaps ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  task automatic send_point(input int x, input int y, input int z, input int inten);
    int n;
    bit taken;
    n = no_gaps ? 0 : $urandom_range(0, 12);
    if (n > 0) begin
      valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    point_x_i <= CoordW'(x);
    point_y_i <= CoordW'(y);
    point_z_i <= CoordW'(z);
    point_intensity_i <= IntenW'(inten);
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Register writes happen only once the pipeline has drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    bit taken;
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_point();
    int x, y, z, r;
    case ($urandom_range(0, 3))
      0: begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end
      1: begin
        x = $urandom_range(0, 4000) - 2000;
        y = $urandom_range(0, 4000) - 2000;
        z = $urandom_range(0, 400) - 200;
      end
      default: begin
        // Points in and around the vertical field of view, so rows spread out.
        x = $urandom_range(0, 160000) - 80000;
        y = $urandom_range(0, 160000) - 80000;
        r = (x < 0 ? -x : x) + (y < 0 ? -y : y);
        z = int'($urandom_range(0, 1000)) * (r / 1000 + 1) / 2 - r * 45 / 100;
      end
    endcase
    send_point(x, y, z, $urandom);
  endtask

  initial begin
    int rows_set[6] = '{0, 1, 128, 8191, 32, 64};
    int cols_set[6] = '{0, 1, 4096, 8191, 360, 1800};
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    point_intensity_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROW_COUNT;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(0, 0, 0, 0);
    send_point(-131072, -131072, -131072, 65535);
    send_point(131071, 131071, 131071, 65534);
    send_point(131071, 0, 0, 257);
    send_point(-131072, 0, 5, 256);
    send_point(-7, 0, -3, 1);
    send_point(0, 0, 100, 32768);
    send_point(0, 0, -100, 514);
    send_point(0, -131072, 0, 255);
    send_point(0, 131071, -131072, 258);
    send_point(-100, -1, 0, 12345);
    send_point(-100, 1, 0, 54321);
    send_point(1000, 0, -433, 0);
    send_point(1000, 0, 32, 65535);
    send_point(-131072, 131071, 131071, 1);
    send_point(131071, -131072, -1, 2);
    write_reg(CfgIdxUnused, 8191);
    send_point(500, 500, 0, 40000);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ROW_COUNT, rows_set[ph]);
      write_reg(CFG_COL_COUNT, cols_set[ph]);
      for (int k = 0; k < 280; k++) begin
        // Every so often a burst without sender or receiver gaps.
        if (k % 70 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        random_point();
      end
      no_gaps = 1'b0;
    end
    valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
